/* rtl/core/ring_buffer_offset_search_core_defines.svh */
// Assertion macros for the ring buffer offset search core.
`ifndef RING_BUFFER_OFFSET_SEARCH_CORE_DEFINES_SVH
`define RING_BUFFER_OFFSET_SEARCH_CORE_DEFINES_SVH
`ifndef SYNTH
`define RBOS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define RBOS_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RBOS_ASSERT(lbl, prop, msg)
`define RBOS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/core/rbos_pkg.sv */
`default_nettype none
package rbos_pkg;

	localparam int SIZE_W   = 16;
	localparam int HANDLE_W = 32;
	localparam int OFF_W    = 20;
	localparam int SLOT_W   = 4;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 88;

	typedef enum logic {
		OP_ADD  = 1'b0,
		OP_FIND = 1'b1
	} op_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] evicted_handle;
		logic                evicted;
		logic [SIZE_W-1:0]   byte_offset;
		logic [HANDLE_W-1:0] found_handle;
		logic [SLOT_W-1:0]   slot_index;
		logic                found;
	} res_t;

endpackage
`default_nettype wire

/* rtl/core/rbos_ram.sv */
`default_nettype none
module rbos_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

/* rtl/core/rbos_cmp.sv */
`default_nettype none
module rbos_cmp #(
	parameter int BW = 21
) (
	input  wire logic [BW-1:0]              base,
	input  wire logic [rbos_pkg::SIZE_W-1:0] size,
	input  wire logic [rbos_pkg::OFF_W-1:0]  coff,
	output logic                            hit,
	output logic      [BW-1:0]              sum,
	output logic      [rbos_pkg::SIZE_W-1:0] diff
);

	localparam int XW = (BW > rbos_pkg::OFF_W) ? BW : rbos_pkg::OFF_W;

	logic [XW-1:0] diff_x;

	assign sum    = base + BW'(size);
	assign hit    = XW'(sum) > XW'(coff);
	assign diff_x = XW'(coff) - XW'(base);
	assign diff   = diff_x[rbos_pkg::SIZE_W-1:0];

endmodule
`default_nettype wire

/* rtl/core/ring_buffer_offset_search_core.sv */
// channel  dir  tdata (low bit up)                                   tuser
// s_*      in   entry_size, entry_handle, find_offset, pad          op
// m_*      out  found, slot_index, found_handle, byte_offset,        -
//               evicted, evicted_handle, pad
// Add: from accept to result the sequencer steps through RAM read of the old slot, write, result.
// Find: the walk reads one RAM entry per cycle, at most the held entries, and
// the single adder/compare checks it.
// One word at a time: s_tready is high only when the sequencer is idle.
// A result waiting on m_tready holds the sequencer; arst_n clears pointers.
`default_nettype none
`include "ring_buffer_offset_search_core_defines.svh"
module ring_buffer_offset_search_core #(
	parameter int DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [rbos_pkg::S_DATA_W-1:0] s_tdata, // size, handle, find_offset
	input  wire logic                          s_tuser, // op
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [rbos_pkg::M_DATA_W-1:0] m_tdata  // found, slot, handle, offset, evicted, ehandle
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int BW  = rbos_pkg::SIZE_W + CW;
	localparam int EW  = rbos_pkg::SIZE_W + rbos_pkg::HANDLE_W;
	localparam int RW  = $bits(rbos_pkg::res_t);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_ADD_RD = 5'b00010,
		ST_ADD_WR = 5'b00100,
		ST_FIND   = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [AW-1:0]                 wptr_q;
	logic [AW-1:0]                 rptr_q;
	logic                          full_q;
	logic [AW-1:0]                 rd_slot_q;
	logic [AW-1:0]                 pend_slot_q;
	logic                          pend_q;
	logic [CW-1:0]                 left_q;
	logic [BW-1:0]                 base_q;
	logic [rbos_pkg::SIZE_W-1:0]   esize_q;
	logic [rbos_pkg::HANDLE_W-1:0] ehandle_q;
	logic [rbos_pkg::OFF_W-1:0]    coff_q;
	rbos_pkg::res_t                res_q;
	logic                          m_tvalid_q;
	logic [RW-1:0]                 m_tdata_q;

	logic [AW-1:0]                 ram_addr;
	logic                          ram_we;
	logic [EW-1:0]                 ram_wdata;
	logic [EW-1:0]                 ram_rdata;
	logic [rbos_pkg::SIZE_W-1:0]   rd_size;
	logic [rbos_pkg::HANDLE_W-1:0] rd_handle;
	logic                          cmp_hit;
	logic [BW-1:0]                 cmp_sum;
	logic [rbos_pkg::SIZE_W-1:0]   cmp_diff;
	logic [CW-1:0]                 count;
	logic [AW-1:0]                 wptr_nx;
	logic                          accept;
	logic                          out_free;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(rbos_pkg::M_DATA_W - RW){1'b0}}, m_tdata_q};
	assign wptr_nx  = ring_next(wptr_q);

	assign count = full_q ? CW'(DEPTH) :
		CW'(wptr_q) - CW'(rptr_q) + ((wptr_q < rptr_q) ? CW'(DEPTH) : CW'(0));

	assign ram_we    = (state_q == ST_ADD_WR);
	assign ram_addr  = (state_q == ST_FIND) ? rd_slot_q : wptr_q;
	assign ram_wdata = {ehandle_q, esize_q};
	assign rd_size   = ram_rdata[rbos_pkg::SIZE_W-1:0];
	assign rd_handle = ram_rdata[EW-1:rbos_pkg::SIZE_W];

	rbos_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	rbos_cmp #(
		.BW (BW)
	) u_cmp (
		.base (base_q),
		.size (rd_size),
		.coff (coff_q),
		.hit  (cmp_hit),
		.sum  (cmp_sum),
		.diff (cmp_diff)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wptr_q     <= '0;
			rptr_q     <= '0;
			full_q     <= 1'b0;
			rd_slot_q  <= '0;
			pend_slot_q <= '0;
			pend_q     <= 1'b0;
			left_q     <= '0;
			base_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESULT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == rbos_pkg::OP_FIND) begin
							state_q   <= ST_FIND;
							rd_slot_q <= rptr_q;
							left_q    <= count;
							pend_q    <= 1'b0;
							base_q    <= '0;
						end else begin
							state_q <= ST_ADD_RD;
						end
					end
				end
				ST_ADD_RD: begin
					state_q <= ST_ADD_WR;
				end
				ST_ADD_WR: begin
					wptr_q <= wptr_nx;
					if (full_q) begin
						rptr_q <= ring_next(rptr_q);
					end else if (wptr_nx == rptr_q) begin
						full_q <= 1'b1;
					end
					state_q <= ST_RESULT;
				end
				ST_FIND: begin
					if (pend_q && cmp_hit) begin
						state_q <= ST_RESULT;
						pend_q  <= 1'b0;
					end else if (!pend_q && left_q == '0) begin
						state_q <= ST_RESULT;
					end else begin
						if (pend_q) begin
							base_q <= cmp_sum;
						end
						pend_slot_q <= rd_slot_q;
						if (left_q != '0) begin
							rd_slot_q <= ring_next(rd_slot_q);
							left_q    <= left_q - CW'(1);
							pend_q    <= 1'b1;
						end else begin
							pend_q <= 1'b0;
						end
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// word payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			esize_q   <= s_tdata[15:0];
			ehandle_q <= s_tdata[47:16];
			coff_q    <= s_tdata[67:48];
		end
		if (state_q == ST_ADD_WR) begin
			res_q <= '{evicted_handle: (full_q ? rd_handle : '0), evicted: full_q,
				byte_offset: '0, found_handle: '0, slot_index: '0, found: 1'b0};
		end
		if (state_q == ST_FIND) begin
			if (pend_q && cmp_hit) begin
				res_q <= '{evicted_handle: '0, evicted: 1'b0, byte_offset: cmp_diff,
					found_handle: rd_handle,
					slot_index: rbos_pkg::SLOT_W'(pend_slot_q), found: 1'b1};
			end else if (!pend_q && left_q == '0) begin
				res_q <= '0;
			end
		end
		if (state_q == ST_RESULT && out_free) begin
			m_tdata_q <= res_q;
		end
	end

	`RBOS_ASSERT(a_accept_leaves_idle, accept |=> state_q != ST_IDLE, "accepted word left idle")
	`RBOS_ASSERT(a_full_ptrs, full_q |-> wptr_q == rptr_q, "ring full with pointers apart")
	`RBOS_ASSERT_NEVER(a_both_flags, state_q == ST_RESULT && res_q.found && res_q.evicted, "both flags")
	`RBOS_ASSERT(a_find_bounded, state_q == ST_FIND |-> left_q <= count, "walk exceeds held entries")

endmodule
`default_nettype wire

/* tb/ring_buffer_offset_search_checker.sv */
`default_nettype none
module ring_buffer_offset_search_checker #(
	parameter int DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic [rbos_pkg::S_DATA_W-1:0] s_tdata, // size, handle, find_offset
	input  wire logic                          s_tuser, // op
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [rbos_pkg::M_DATA_W-1:0] m_tdata, // found, slot, handle, offset, evicted, ehandle
	output int                                 errors,
	output int                                 pending
);

	logic [rbos_pkg::SIZE_W-1:0]   ring_size   [DEPTH];
	logic [rbos_pkg::HANDLE_W-1:0] ring_handle [DEPTH];
	int unsigned                   wr_ptr = 0;
	int unsigned                   rd_ptr = 0;
	bit                            ring_full = 0;
	rbos_pkg::res_t                expected_results [$];
	int unsigned                   words_in = 0;
	int unsigned                   words_out = 0;
	rbos_pkg::res_t                got;
	rbos_pkg::res_t                want;

	initial errors = 0;
	assign pending = int'(words_in - words_out);

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t, result %0d: %s", $time, words_out, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] g, input logic [31:0] w);
		if (g !== w)
			report_mismatch($sformatf("%s got %h want %h", name, g, w));
	endtask

	// applies one word to the shadow ring and returns the result it causes
	function automatic rbos_pkg::res_t ring_update_and_lookup(input rbos_pkg::op_t op,
			input logic [rbos_pkg::SIZE_W-1:0] sz, input logic [rbos_pkg::HANDLE_W-1:0] hdl,
			input logic [rbos_pkg::OFF_W-1:0] off);
		rbos_pkg::res_t r;
		int unsigned    held;
		int unsigned    slot;
		int unsigned    base;
		int unsigned    i;
		bit             was_full;
		r = '0;
		if (op == rbos_pkg::OP_ADD) begin
			was_full = ring_full;
			if (was_full) begin
				r.evicted        = 1'b1;
				r.evicted_handle = ring_handle[wr_ptr];
			end
			ring_size[wr_ptr]   = sz;
			ring_handle[wr_ptr] = hdl;
			wr_ptr = (wr_ptr + 1) % DEPTH;
			if (was_full)
				rd_ptr = (rd_ptr + 1) % DEPTH;
			else if (wr_ptr == rd_ptr)
				ring_full = 1'b1;
		end else begin
			held = ring_full ? DEPTH : (wr_ptr + DEPTH - rd_ptr) % DEPTH;
			slot = rd_ptr;
			base = 0;
			for (i = 0; i < held && !r.found; i++) begin
				if (base + ring_size[slot] > off) begin
					r.found        = 1'b1;
					r.slot_index   = rbos_pkg::SLOT_W'(slot);
					r.found_handle = ring_handle[slot];
					r.byte_offset  = rbos_pkg::SIZE_W'(off - base);
				end else begin
					base += ring_size[slot];
					slot = (slot + 1) % DEPTH;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = rbos_pkg::res_t'(m_tdata[$bits(rbos_pkg::res_t)-1:0]);
				if (expected_results.size() == 0) begin
					report_mismatch("result word with none expected");
				end else begin
					want = expected_results.pop_front();
					check_field("found", 32'(got.found), 32'(want.found));
					check_field("slot_index", 32'(got.slot_index), 32'(want.slot_index));
					check_field("found_handle", got.found_handle, want.found_handle);
					check_field("byte_offset", 32'(got.byte_offset), 32'(want.byte_offset));
					check_field("evicted", 32'(got.evicted), 32'(want.evicted));
					check_field("evicted_handle", got.evicted_handle, want.evicted_handle);
				end
				words_out <= words_out + 1;
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(ring_update_and_lookup(rbos_pkg::op_t'(s_tuser),
					s_tdata[15:0], s_tdata[47:16], s_tdata[67:48]));
				words_in <= words_in + 1;
			end
		end
	end

endmodule
`default_nettype wire

/* tb/tb_ring_buffer_offset_search_core.sv */
`default_nettype none
module tb_ring_buffer_offset_search_core;

	localparam int DEPTH      = 16;
	localparam int QUIET_MAX  = 5000;
	localparam int RAND_WORDS = 1425;
	localparam int DRAIN_AT   = 700;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [rbos_pkg::S_DATA_W-1:0] s_tdata = '0;
	logic                          s_tuser = rbos_pkg::OP_ADD;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [rbos_pkg::M_DATA_W-1:0] m_tdata;
	int                            errors;
	int                            pending;
	int                            quiet = 0;

	always #5 clk = ~clk;

	ring_buffer_offset_search_core #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	ring_buffer_offset_search_checker #(.DEPTH(DEPTH)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	// watchdog: cycles with no word moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_MAX) begin
				$display("timeout at %0t", $time);
				$display("tb_ring_buffer_offset_search_core failed");
				$finish;
			end
		end
	end

	task automatic offer_word(input rbos_pkg::op_t op, input logic [rbos_pkg::SIZE_W-1:0] sz,
			input logic [rbos_pkg::HANDLE_W-1:0] hdl, input logic [rbos_pkg::OFF_W-1:0] off);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= rbos_pkg::S_DATA_W'({off, hdl, sz});
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 50)
			n = 0;
		else if (r < 85)
			n = $urandom_range(1, 3);
		else if (r < 97)
			n = $urandom_range(4, 10);
		else
			n = $urandom_range(20, 60);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [rbos_pkg::SIZE_W-1:0] rand_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return rbos_pkg::SIZE_W'($urandom_range(1, 300));
		else if (r < 65)
			return '0;
		else if (r < 85)
			return rbos_pkg::SIZE_W'($urandom_range(0, 20000));
		else
			return rbos_pkg::SIZE_W'($urandom);
	endfunction

	function automatic logic [rbos_pkg::OFF_W-1:0] rand_offset();
		int r;
		r = $urandom_range(0, 3);
		if (r < 2)
			return rbos_pkg::OFF_W'($urandom_range(0, 3000));
		else if (r == 2)
			return rbos_pkg::OFF_W'($urandom_range(0, 300000));
		else
			return rbos_pkg::OFF_W'($urandom);
	endfunction

	// receiver: runs of ready, random toggling, short and long stalls, one long hold-off
	initial begin
		int r;
		int n;
		int cyc;
		bit held;
		cyc  = 0;
		held = 0;
		while (!arst_n) @(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (!held && cyc >= 4000) begin
				m_tready <= 1'b0;
				n    = 600;
				held = 1;
			end else if (r < 40) begin
				m_tready <= 1'b1;
				n = $urandom_range(1, 40);
			end else if (r < 80) begin
				m_tready <= 1'($urandom_range(0, 1));
				n = 1;
			end else begin
				m_tready <= 1'b0;
				n = (r < 97) ? $urandom_range(1, 3) : $urandom_range(20, 60);
			end
			repeat (n) @(posedge clk);
			cyc += n;
		end
	end

	initial begin
		int i;
		int r;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring, zero-size entry, widest entry, offsets around the edges
		offer_word(rbos_pkg::OP_FIND, '0, '0, '0);
		offer_word(rbos_pkg::OP_ADD, '0, '0, '0);
		offer_word(rbos_pkg::OP_ADD, '1, '1, '0);
		offer_word(rbos_pkg::OP_ADD, 16'd1, 32'h1234_5678, '0);
		offer_word(rbos_pkg::OP_FIND, '0, '0, '0);
		offer_word(rbos_pkg::OP_FIND, '0, '0, 20'd65534);
		offer_word(rbos_pkg::OP_FIND, '0, '0, 20'd65535);
		offer_word(rbos_pkg::OP_FIND, '0, '0, 20'd65536);
		offer_word(rbos_pkg::OP_FIND, '0, '0, '1);
		// fill the ring, then overwrite the oldest
		for (i = 0; i < DEPTH - 3; i++) begin
			idle_gap();
			offer_word(rbos_pkg::OP_ADD, rand_size(), $urandom, '0);
		end
		offer_word(rbos_pkg::OP_ADD, 16'd7, 32'hA5A5_5A5A, '0);
		offer_word(rbos_pkg::OP_FIND, '0, '0, '0);
		offer_word(rbos_pkg::OP_FIND, '0, '0, '1);

		for (i = 0; i < RAND_WORDS; i++) begin
			if (i == DRAIN_AT) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending != 0);
			end
			idle_gap();
			r = $urandom_range(0, 99);
			if (r < 65)
				offer_word(rbos_pkg::OP_ADD, rand_size(), $urandom,
					rbos_pkg::OFF_W'($urandom));
			else
				offer_word(rbos_pkg::OP_FIND, rbos_pkg::SIZE_W'($urandom), $urandom,
					rand_offset());
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_ring_buffer_offset_search_core passed");
		else
			$display("tb_ring_buffer_offset_search_core failed");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
+incdir+rtl/core
rtl/core/rbos_pkg.sv
rtl/core/rbos_ram.sv
rtl/core/rbos_cmp.sv
rtl/core/ring_buffer_offset_search_core.sv
tb/ring_buffer_offset_search_checker.sv
tb/tb_ring_buffer_offset_search_core.sv
